// ===== src/mds_pkg.sv =====
// mds_pkg: shared types, codes and reset values for the motor dispense sequencer
// used by mds_core, motor_dispense_sequencer_top and mds_checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mds_pkg;

    // command codes carried by an input beat
    localparam logic [1:0] CMD_START_FWD = 2'd0;
    localparam logic [1:0] CMD_START_REV = 2'd1;
    localparam logic [1:0] CMD_TICK      = 2'd2;
    localparam logic [1:0] CMD_ACK       = 2'd3;

    // status codes
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_FWD      = 4'd1;
    localparam logic [3:0] ST_REV      = 4'd2;
    localparam logic [3:0] ST_FWD_DONE = 4'd3;
    localparam logic [3:0] ST_REV_DONE = 4'd4;
    localparam logic [3:0] ST_STALL    = 4'd5;
    localparam logic [3:0] ST_BEAM     = 4'd6;
    localparam logic [3:0] ST_TIMEOUT  = 4'd7;
    localparam logic [3:0] ST_EMPTY    = 4'd8;
    localparam logic [3:0] ST_FULL     = 4'd9;

    // direction and drive codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_STOCK_MAX     = 2'd0;
    localparam logic [1:0] REG_STALL_GRACE   = 2'd1;
    localparam logic [1:0] REG_ARRIVE_GRACE  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

    // configuration reset values
    localparam logic [7:0]  STOCK_MAX_RST     = 8'd16;
    localparam logic [9:0]  STALL_GRACE_RST   = 10'd10;
    localparam logic [9:0]  ARRIVE_GRACE_RST  = 10'd100;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd300;

    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [7:0]  stock_max;
        logic [9:0]  stall_grace;
        logic [9:0]  arrive_grace;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] stock_count;
        logic       beam_blocked;
        logic       stall_sense;
        logic       end_switch;
    } item_t;

    typedef struct packed {
        logic [3:0]  run_status;
        logic [15:0] tick_count;
        logic [1:0]  last_direction;
        logic [1:0]  drive_state;
        logic        lamp_state;
        logic        active_flag;
    } seq_state_t;

    typedef struct packed {
        logic [3:0] status;
        logic [1:0] direction;
        logic [1:0] motor_drive;
        logic       status_lamp;
        logic       running;
        logic       finished;
    } result_t;

endpackage

`default_nettype wire

// ===== src/mds_core.sv =====
// mds_core: next-state and result logic for one command beat
// depends on mds_pkg
`timescale 1ns / 1ps
`default_nettype none

module mds_core (
    input  mds_pkg::cfg_t       cfg,
    input  mds_pkg::item_t      item,
    input  mds_pkg::seq_state_t cur,
    output mds_pkg::seq_state_t nxt,
    output mds_pkg::result_t    res
);
    import mds_pkg::*;

    logic        start_fwd;
    logic [1:0]  start_dir;
    logic        stock_refused;
    logic        hit_stall;
    logic        early_hit;
    logic [15:0] tick_after_early;
    logic        hit_end;
    logic [15:0] tick_after_end;
    logic        hit_timeout;
    logic        tick_hit;
    logic [3:0]  tick_status;
    logic        fin;

    // start decode
    assign start_fwd     = (item.command == CMD_START_FWD);
    assign start_dir     = start_fwd ? DIR_FWD : DIR_REV;
    assign stock_refused = start_fwd ? (item.stock_count == 8'd0)
                                     : (item.stock_count >= cfg.stock_max);

    // tick checks in order; each hit clears the counter seen by later checks
    assign hit_stall        = (cur.tick_count > {6'd0, cfg.stall_grace}) && item.stall_sense;
    assign early_hit        = hit_stall || item.beam_blocked;
    assign tick_after_early = early_hit ? 16'd0 : cur.tick_count;
    assign hit_end          = (tick_after_early > {6'd0, cfg.arrive_grace}) && item.end_switch;
    assign tick_after_end   = hit_end ? 16'd0 : tick_after_early;
    assign hit_timeout      = (tick_after_end >= cfg.timeout_ticks);
    assign tick_hit         = early_hit || hit_end || hit_timeout;

    // status after a tick; the last hit wins
    always_comb
    begin
        tick_status = cur.run_status;
        if (hit_stall)
        begin
            tick_status = ST_STALL;
        end
        if (item.beam_blocked)
        begin
            tick_status = ST_BEAM;
        end
        if (hit_end)
        begin
            if (tick_status == ST_FWD)
            begin
                tick_status = ST_FWD_DONE;
            end
            else if (tick_status == ST_REV)
            begin
                tick_status = ST_REV_DONE;
            end
        end
        if (hit_timeout)
        begin
            tick_status = ST_TIMEOUT;
        end
    end

    // command dispatch
    always_comb
    begin
        nxt = cur;
        fin = 1'b0;
        case (item.command)
            CMD_START_FWD, CMD_START_REV:
            begin
                nxt.active_flag    = 1'b0;
                nxt.tick_count     = 16'd0;
                nxt.last_direction = start_dir;
                if (stock_refused)
                begin
                    nxt.run_status = start_fwd ? ST_EMPTY : ST_FULL;
                    fin            = 1'b1;
                end
                else if (item.beam_blocked)
                begin
                    nxt.run_status = ST_BEAM;
                    fin            = 1'b1;
                end
                else
                begin
                    nxt.run_status  = {2'b00, start_dir};
                    nxt.lamp_state  = 1'b1;
                    nxt.drive_state = start_dir;
                    nxt.active_flag = 1'b1;
                end
            end
            CMD_TICK:
            begin
                if (cur.active_flag)
                begin
                    nxt.run_status = tick_status;
                    if (tick_hit)
                    begin
                        nxt.lamp_state  = 1'b0;
                        nxt.active_flag = 1'b0;
                        nxt.drive_state = DIR_NONE;
                    end
                    // counter advances unless the timeout fired
                    nxt.tick_count = hit_timeout ? 16'd0 : (tick_after_end + 16'd1);
                    fin            = tick_hit;
                end
            end
            CMD_ACK:
            begin
                if (cur.run_status >= ST_FWD_DONE)
                begin
                    nxt.run_status = ST_IDLE;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    // result fields come from the updated state; finished comes from the dispatch
    assign res.status      = nxt.run_status;
    assign res.direction   = nxt.last_direction;
    assign res.motor_drive = nxt.drive_state;
    assign res.status_lamp = nxt.lamp_state;
    assign res.running     = nxt.active_flag;
    assign res.finished    = fin;

endmodule

`default_nettype wire

// ===== src/motor_dispense_sequencer_top.sv =====
// Motor dispense sequencer, top level.
// A command beat is held in the input register, then passes through the decision logic into
// the result register; either register holds its beat while the stage after it stalls.
// Throughput: one command beat per cycle while out_stall holds no beat; state and result load together.
// Reset: rst_n async low; status idle, motor stopped, counter zero, config defaults.
// Depends on mds_pkg and mds_core.
`timescale 1ns / 1ps
`default_nettype none

module motor_dispense_sequencer_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write port
    input  wire logic                             cfg_write_en,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [mds_pkg::CFG_DATA_W-1:0]   cfg_data,
    // command channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [1:0]                       command,
    input  wire logic [7:0]                       stock_count,
    input  wire logic                             beam_blocked,
    input  wire logic                             stall_sense,
    input  wire logic                             end_switch,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [3:0]                            status,
    output logic [1:0]                            direction,
    output logic [1:0]                            motor_drive,
    output logic                                  status_lamp,
    output logic                                  running,
    output logic                                  finished
);
    import mds_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    item_t      s1_item_reg;
    item_t      s1_item_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    result_reg;
    result_t    result_next;
    seq_state_t state_reg;
    seq_state_t state_next;
    seq_state_t core_state;
    result_t    core_res;
    logic       in_take;
    logic       s2_load;

    // handshake
    assign s2_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s2_load;
    assign in_take  = in_valid && !in_stall;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_STOCK_MAX:     cfg_next.stock_max     = cfg_data[7:0];
                REG_STALL_GRACE:   cfg_next.stall_grace   = cfg_data[9:0];
                REG_ARRIVE_GRACE:  cfg_next.arrive_grace  = cfg_data[9:0];
                REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // input register
    always_comb
    begin
        s1_valid_next = in_take || (s1_valid_reg && !s2_load);
        s1_item_next  = s1_item_reg;
        if (in_take)
        begin
            s1_item_next.command      = command;
            s1_item_next.stock_count  = stock_count;
            s1_item_next.beam_blocked = beam_blocked;
            s1_item_next.stall_sense  = stall_sense;
            s1_item_next.end_switch   = end_switch;
        end
    end

    // sequencer decision
    mds_core u_core (
        .cfg  (cfg_reg),
        .item (s1_item_reg),
        .cur  (state_reg),
        .nxt  (core_state),
        .res  (core_res)
    );

    // state and result register
    always_comb
    begin
        state_next     = s2_load ? core_state : state_reg;
        result_next    = s2_load ? core_res : result_reg;
        out_valid_next = s2_load || (out_valid_reg && out_stall);
    end

    // control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stock_max     <= STOCK_MAX_RST;
            cfg_reg.stall_grace   <= STALL_GRACE_RST;
            cfg_reg.arrive_grace  <= ARRIVE_GRACE_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.run_status     <= ST_IDLE;
            state_reg.tick_count     <= 16'd0;
            state_reg.last_direction <= DIR_NONE;
            state_reg.drive_state    <= DIR_NONE;
            state_reg.lamp_state     <= 1'b0;
            state_reg.active_flag    <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        result_reg  <= result_next;
    end

    // outputs
    assign out_valid   = out_valid_reg;
    assign status      = result_reg.status;
    assign direction   = result_reg.direction;
    assign motor_drive = result_reg.motor_drive;
    assign status_lamp = result_reg.status_lamp;
    assign running     = result_reg.running;
    assign finished    = result_reg.finished;

endmodule

`default_nettype wire

// ===== src/mds_checker.sv =====
// mds_checker: port-level assertions for the motor dispense sequencer
// depends on mds_pkg; bound to motor_dispense_sequencer_top
`timescale 1ns / 1ps
`default_nettype none

module mds_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [3:0] status,
    input wire logic [1:0] direction,
    input wire logic [1:0] motor_drive,
    input wire logic       status_lamp,
    input wire logic       running,
    input wire logic       finished
);
    import mds_pkg::*;

    // a stalled result beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // a finishing beat carries a final status and is no longer running
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> !running && status >= ST_FWD_DONE && status <= ST_FULL)
        else $error("finished beat without final status");

    // while running the lamp is lit and the motor follows the requested direction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && running |-> status_lamp && motor_drive == direction
                                 && (status == ST_FWD || status == ST_REV))
        else $error("running beat with inconsistent drive");

    // status never leaves its code range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_FULL)
        else $error("status code out of range");

endmodule

bind motor_dispense_sequencer_top mds_checker u_mds_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .direction   (direction),
    .motor_drive (motor_drive),
    .status_lamp (status_lamp),
    .running     (running),
    .finished    (finished)
);

`default_nettype wire
